// ===== hdl/fsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// FASTA stream parser package
// Shared types, character constants, result codes and the per-character
// update functions of the line state machine.
// ----------------------------------------------------------------------------
package fsp_pkg;

   // Characters of interest
   localparam logic [7:0] CHAR_GT    = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Input item kinds
   localparam logic REQ_TEXT = 1'b0;
   localparam logic REQ_EOI  = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_ID  = 2'd0;
   localparam logic [1:0] KIND_SEQ = 2'd1;
   localparam logic [1:0] KIND_END = 2'd2;
   localparam logic [1:0] KIND_ERR = 2'd3;

   // Error codes
   localparam logic [1:0] ERR_EMPTY_SEQ = 2'd0;
   localparam logic [1:0] ERR_EMPTY_HDR = 2'd1;
   localparam logic [1:0] ERR_ILLEGAL   = 2'd2;

   // Line mode, one-hot
   typedef enum logic [4:0] {
      MODE_START = 5'b00001,
      MODE_ID    = 5'b00010,
      MODE_REST  = 5'b00100,
      MODE_SEQ   = 5'b01000,
      MODE_ERROR = 5'b10000
   } mode_type;

   // Parser control state
   typedef struct packed {
      mode_type mode;
      logic     header_seen;
      logic     sequence_nonempty;
      logic     id_char_seen;
      logic     pending_cr;
      logic     line_has_chars;
   } ctl_type;

   localparam ctl_type CTL_RESET = '{
      mode:              MODE_START,
      header_seen:       1'b0,
      sequence_nonempty: 1'b0,
      id_char_seen:      1'b0,
      pending_cr:        1'b0,
      line_has_chars:    1'b0
   };

   // Outcome of one parser operation: new state and at most one result
   typedef struct packed {
      ctl_type    ctl;
      logic       emit;
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [1:0] code;
      logic       last;
      logic       inc_line;
      logic       inc_rec;
   } step_type;

   // No-op outcome carrying the given state
   function automatic step_type step_nop(input ctl_type s);
      step_type r;
      r          = '0;
      r.ctl      = s;
      return r;
   endfunction

   // Raise an error: enter error mode and emit the final error result
   function automatic step_type step_error(input ctl_type s, input logic [1:0] code);
      step_type r;
      r          = step_nop(s);
      r.ctl.mode = MODE_ERROR;
      r.emit     = 1'b1;
      r.kind     = KIND_ERR;
      r.code     = code;
      r.last     = 1'b1;
      return r;
   endfunction

   // Nucleotide codes A C G T U R Y K M S W B D H N X and '-', either case (IUPAC set without V)
   function automatic logic is_iupac(input logic [7:0] c);
      logic [7:0] u;
      logic       ok;
      u = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         u = c - 8'h20;
      end
      case (u) inside
         8'h41, 8'h43, 8'h47, 8'h54, 8'h55, 8'h52, 8'h59, 8'h4B, 8'h4D,
         8'h53, 8'h57, 8'h42, 8'h44, 8'h48, 8'h4E, 8'h58, 8'h2D: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   // One character of a line (not CR/LF handling)
   function automatic step_type line_char(input ctl_type s, input logic [7:0] c);
      step_type r;
      logic     done;
      r    = step_nop(s);
      done = 1'b0;
      // first character of a line: header or sequence
      if (s.mode == MODE_START) begin
         r.ctl.line_has_chars = 1'b1;
         if (c == CHAR_GT) begin
            done = 1'b1;
            if (s.header_seen && !s.sequence_nonempty) begin
               r = step_error(r.ctl, ERR_EMPTY_SEQ);
            end else begin
               if (s.header_seen) begin
                  r.emit                  = 1'b1;
                  r.kind                  = KIND_END;
                  r.inc_rec               = 1'b1;
                  r.ctl.sequence_nonempty = 1'b0;
               end
               r.ctl.header_seen  = 1'b1;
               r.ctl.id_char_seen = 1'b0;
               r.ctl.mode         = MODE_ID;
            end
         end else begin
            r.ctl.mode = MODE_SEQ;
         end
      end
      // id bytes up to the first space
      if (!done && r.ctl.mode == MODE_ID) begin
         done = 1'b1;
         if (c == CHAR_SPACE) begin
            if (!r.ctl.id_char_seen) begin
               r = step_error(r.ctl, ERR_EMPTY_HDR);
            end else begin
               r.ctl.mode = MODE_REST;
            end
         end else begin
            r.ctl.id_char_seen = 1'b1;
            r.emit             = 1'b1;
            r.kind             = KIND_ID;
            r.out_byte         = c;
         end
      end
      // sequence bytes, checked
      if (!done && r.ctl.mode == MODE_SEQ) begin
         if (!is_iupac(c)) begin
            r = step_error(r.ctl, ERR_ILLEGAL);
         end else begin
            r.ctl.sequence_nonempty = 1'b1;
            r.emit                  = 1'b1;
            r.kind                  = KIND_SEQ;
            r.out_byte              = c;
         end
      end
      return r;
   endfunction

   // End of a line
   function automatic step_type end_line(input ctl_type s);
      step_type r;
      r = step_nop(s);
      if (s.mode != MODE_ERROR) begin
         if (s.mode == MODE_ID && !s.id_char_seen) begin
            r = step_error(s, ERR_EMPTY_HDR);
         end else begin
            r.inc_line           = s.line_has_chars;
            r.ctl.mode           = MODE_START;
            r.ctl.line_has_chars = 1'b0;
         end
      end
      return r;
   endfunction

endpackage : fsp_pkg
`default_nettype wire

// ===== hdl/fasta_stream_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// FASTA stream parser
// Parses FASTA text one byte per item and emits id bytes, sequence bytes,
// record ends and errors.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one item per byte of text (req_kind 0) or end of input (req_kind 1).
//   rsp_* : result items: id byte, sequence byte, record end or error, with the
//           record number and line number at that point. rsp_last marks the
//           final record end or the error that ends a parse.
//   Each input item gives zero, one or two result items. The parser state is
//   updated in the cycle the item is taken and its results are written into
//   a four-entry result queue; the first result is offered on rsp_* in the
//   next cycle if the queue was empty.
//   Throughput: one input item per cycle while req_stall is low. req_stall
//   rises while fewer than two queue entries are free; the single result port
//   sends the two results of an item one after the other.
//   After an error, text is swallowed until end of input; end of input
//   always returns the parser to its reset state.
//   Reset empties the queue and puts the parser at the start of a line with
//   both counters at one. A stalled receiver fills the queue, after which
//   req_stall holds off the sender; nothing is lost.
// ----------------------------------------------------------------------------
module fasta_stream_parser #(
   parameter int LINE_COUNT_BITS   = 32,
   parameter int RECORD_COUNT_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_data_byte,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_out_kind,
   output logic [7:0]       rsp_out_byte,
   output logic [31:0]      rsp_record_number,
   output logic [1:0]       rsp_error_code,
   output logic [31:0]      rsp_line_number,
   output logic             rsp_last
);
   import fsp_pkg::*;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  out_byte;
      logic [31:0] record_number;
      logic [1:0]  error_code;
      logic [31:0] line_number;
      logic        last;
   } res_type;

   // parser state
   ctl_type                        ctl_ff, ctl_in;
   logic [LINE_COUNT_BITS-1:0]     line_cnt_ff, line_cnt_in, line_sat;
   logic [RECORD_COUNT_BITS-1:0]   rec_cnt_ff, rec_cnt_in, rec_sat;

   // result queue
   res_type                        queue_ff [QDEPTH];
   logic [QPTR_W-1:0]              wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr2_idx;
   logic [QCNT_W-1:0]              count_ff, count_in;

   // step evaluation
   step_type                       st1, st2;
   ctl_type                        c0;
   logic                           go2;
   logic                           req_fire, rsp_fire;
   res_type                        ent1, ent2;
   logic [1:0]                     push_n;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;

   // saturating counter increments
   assign line_sat = (line_cnt_ff == '1) ? line_cnt_ff : line_cnt_ff + 1'b1;
   assign rec_sat  = (rec_cnt_ff == '1) ? rec_cnt_ff : rec_cnt_ff + 1'b1;

   // one item: for text, pending CR (if any) first, then the new byte
   always_comb begin
      st1 = step_nop(ctl_ff);
      st2 = step_nop(ctl_ff);
      c0  = ctl_ff;
      go2 = 1'b0;
      c0.pending_cr = 1'b0;
      if (req_kind == REQ_TEXT) begin
         if (ctl_ff.mode != MODE_ERROR) begin
            if (ctl_ff.pending_cr) begin
               if (req_data_byte == CHAR_LF) begin
                  st1 = end_line(c0);
               end else begin
                  st1 = line_char(c0, CHAR_CR);
                  go2 = (st1.ctl.mode != MODE_ERROR);
               end
            end else begin
               go2 = 1'b1;
            end
            st2 = step_nop(st1.ctl);
            if (go2) begin
               if (req_data_byte == CHAR_CR) begin
                  st2.ctl.pending_cr = 1'b1;
               end else if (req_data_byte == CHAR_LF) begin
                  st2 = end_line(st1.ctl);
               end else begin
                  st2 = line_char(st1.ctl, req_data_byte);
               end
            end
         end
      end else begin
         // end of input: finish the open line, then close the record
         if (ctl_ff.mode != MODE_ERROR) begin
            st1 = end_line(c0);
            st2 = step_nop(st1.ctl);
            if (st1.ctl.mode != MODE_ERROR) begin
               if (!st1.ctl.sequence_nonempty) begin
                  st2 = step_error(st1.ctl, ERR_EMPTY_SEQ);
               end else begin
                  st2.emit = 1'b1;
                  st2.kind = KIND_END;
                  st2.last = 1'b1;
               end
            end
         end
      end
   end

   // next parser state
   always_comb begin
      ctl_in      = ctl_ff;
      line_cnt_in = line_cnt_ff;
      rec_cnt_in  = rec_cnt_ff;
      if (req_fire) begin
         if (req_kind == REQ_EOI) begin
            ctl_in      = CTL_RESET;
            line_cnt_in = LINE_COUNT_BITS'(1);
            rec_cnt_in  = RECORD_COUNT_BITS'(1);
         end else begin
            ctl_in = st2.ctl;
            if (st1.inc_line || st2.inc_line) begin
               line_cnt_in = line_sat;
            end
            if (st1.inc_rec || st2.inc_rec) begin
               rec_cnt_in = rec_sat;
            end
         end
      end
   end

   // result entries; the second sees counters after the first operation
   always_comb begin
      ent1.out_kind      = st1.kind;
      ent1.out_byte      = st1.out_byte;
      ent1.record_number = 32'(rec_cnt_ff);
      ent1.error_code    = st1.code;
      ent1.line_number   = 32'(line_cnt_ff);
      ent1.last          = st1.last;
      ent2.out_kind      = st2.kind;
      ent2.out_byte      = st2.out_byte;
      ent2.record_number = st1.inc_rec ? 32'(rec_sat) : 32'(rec_cnt_ff);
      ent2.error_code    = st2.code;
      ent2.line_number   = st1.inc_line ? 32'(line_sat) : 32'(line_cnt_ff);
      ent2.last          = st2.last;
   end

   // queue pointers and fill level
   assign push_n    = req_fire ? (2'(st1.emit) + 2'(st2.emit)) : 2'd0;
   assign wr2_idx   = wr_ptr_ff + QPTR_W'(st1.emit);
   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(rsp_fire);
   assign count_in  = count_ff + QCNT_W'(push_n) - QCNT_W'(rsp_fire);

   assign req_stall = (count_ff > QCNT_W'(QDEPTH - 2));
   assign rsp_valid = (count_ff != '0);

   // result port
   assign rsp_out_kind      = queue_ff[rd_ptr_ff].out_kind;
   assign rsp_out_byte      = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_record_number = queue_ff[rd_ptr_ff].record_number;
   assign rsp_error_code    = queue_ff[rd_ptr_ff].error_code;
   assign rsp_line_number   = queue_ff[rd_ptr_ff].line_number;
   assign rsp_last          = queue_ff[rd_ptr_ff].last;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff      <= CTL_RESET;
         line_cnt_ff <= LINE_COUNT_BITS'(1);
         rec_cnt_ff  <= RECORD_COUNT_BITS'(1);
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         ctl_ff      <= ctl_in;
         line_cnt_ff <= line_cnt_in;
         rec_cnt_ff  <= rec_cnt_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (req_fire && st1.emit) begin
         queue_ff[wr_ptr_ff] <= ent1;
      end
      if (req_fire && st2.emit) begin
         queue_ff[wr2_idx] <= ent2;
      end
   end

`ifndef SYNTHESIS
   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("result queue overfilled");

   // text swallowed in error mode gives no result and keeps error mode
   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_kind == REQ_TEXT && ctl_ff.mode == MODE_ERROR)
      |-> (push_n == 2'd0) ##1 (ctl_ff.mode == MODE_ERROR))
      else $error("result produced while swallowing after error");

   // end of input always returns the parser to reset state
   a_eoi_reset: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_kind == REQ_EOI)
      |=> (ctl_ff == CTL_RESET && line_cnt_ff == LINE_COUNT_BITS'(1)
           && rec_cnt_ff == RECORD_COUNT_BITS'(1)))
      else $error("parser not reset after end of input");

   // fill level tracks pushes and pops
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == $past(count_ff) + QCNT_W'($past(push_n))
                                   - QCNT_W'($past(rsp_fire)))
      else $error("result queue level mismatch");
`endif

endmodule : fasta_stream_parser
`default_nettype wire
